// File: rtl/core/btlpm_pkg.sv
// Shared types and constants for the binary trie longest prefix match block.
// Used by every module under rtl/core except btlpm_ram; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package btlpm_pkg;

	localparam int NODES_DEF   = 1024;
	localparam int ID_BITS_DEF = 16;

	localparam int ADDR_W  = 32;
	localparam int LEN_W   = 6;
	localparam int ROUTE_W = 16;

	localparam logic [LEN_W-1:0] MAX_LEN = 6'd32;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic               func;
		logic [ADDR_W-1:0]  addr;
		logic [LEN_W-1:0]   prefix_len;
		logic [ROUTE_W-1:0] route_id;
	} req_t;

	typedef struct packed {
		logic               hit;
		logic [ROUTE_W-1:0] match_id;
		logic               status;
	} rsp_t;

	// A request after classification, as it waits in the command queue.
	typedef struct packed {
		logic               lookup;
		logic [ADDR_W-1:0]  addr;
		logic [LEN_W-1:0]   depth;
		logic [ROUTE_W-1:0] route_id;
	} cmd_t;

	typedef struct packed {
		logic valid;
		logic ready;
	} hs_t;

endpackage

`default_nettype wire

// File: rtl/core/btlpm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds the trie nodes; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

module btlpm_ram #(
	parameter int WIDTH = 37,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/btlpm_front.sv
// Front end: takes request beats, classifies them and queues them as commands.
// Depends on btlpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module btlpm_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire btlpm_pkg::req_t   req,
	output btlpm_pkg::hs_t         cmd_hs_out,
	input  wire logic              cmd_ready,
	output btlpm_pkg::cmd_t        cmd
);

	localparam int QD = 2;

	btlpm_pkg::cmd_t queue_q [QD];
	logic [1:0]      count_q;
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic            push;
	logic            pop;
	btlpm_pkg::cmd_t cls;

	// Lookups get the full address length as depth; inserts stop at the saturated length.
	always_comb begin
		cls.lookup   = (req.func == btlpm_pkg::FUNC_LOOKUP);
		cls.addr     = req.addr;
		cls.route_id = req.route_id;
		if (cls.lookup || req.prefix_len > btlpm_pkg::MAX_LEN) begin
			cls.depth = btlpm_pkg::MAX_LEN;
		end else begin
			cls.depth = req.prefix_len;
		end
	end

	assign req_ready        = (count_q != 2'(QD));
	assign push             = req_valid && req_ready;
	assign cmd_hs_out.valid = (count_q != 2'd0);
	assign cmd_hs_out.ready = cmd_ready;
	assign pop              = cmd_hs_out.valid && cmd_ready;
	assign cmd              = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/btlpm_walk.sv
// Back end: walks the trie one level per cycle for inserts and lookups,
// owns the node RAM, the root node and the response register.
// Depends on btlpm_pkg and btlpm_ram.
`timescale 1ns / 1ps
`default_nettype none

module btlpm_walk #(
	parameter int NODES   = btlpm_pkg::NODES_DEF,
	parameter int ID_BITS = btlpm_pkg::ID_BITS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire btlpm_pkg::hs_t  cmd_hs_in,
	output logic                 cmd_ready,
	input  wire btlpm_pkg::cmd_t cmd,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output btlpm_pkg::rsp_t      rsp
);

	localparam int IDX_W  = $clog2(NODES);
	localparam int FREE_W = IDX_W + 1;
	localparam int ENT_W  = 2 * IDX_W + 1 + ID_BITS;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_STEP = 1'b1;

	typedef struct packed {
		logic [IDX_W-1:0]   left;
		logic [IDX_W-1:0]   right;
		logic               vld;
		logic [ID_BITS-1:0] id;
	} node_t;

	logic                                state_q;
	logic                                lookup_q;
	logic [btlpm_pkg::ADDR_W-1:0]        addr_q;
	logic [btlpm_pkg::LEN_W-1:0]         len_q;
	logic [btlpm_pkg::LEN_W-1:0]         depth_q;
	logic [ID_BITS-1:0]                  id_q;
	logic [IDX_W-1:0]                    cur_q;
	node_t                               node_q;
	logic                                from_ram_q;
	logic                                hit_q;
	logic [ID_BITS-1:0]                  best_q;
	logic [FREE_W-1:0]                   free_q;
	node_t                               root_q;
	logic                                rsp_valid_q;
	btlpm_pkg::rsp_t                     rsp_q;

	logic [ENT_W-1:0] rd_data;
	node_t            node_cur;
	node_t            node_wr;
	logic [IDX_W-1:0] slot;
	logic [IDX_W-1:0] free_idx;
	logic             level_end;
	logic             pool_full;
	logic             out_free;
	logic             hit_now;
	logic [ID_BITS-1:0] best_now;
	logic             finish;
	logic             descend;
	logic             alloc;
	logic             do_write;
	logic             advance;
	btlpm_pkg::rsp_t  rsp_next;

	// A freshly allocated node is known to be clear, so it is held in node_q
	// and only reaches the RAM once its child or route is known, or the pool is full.
	assign node_cur  = from_ram_q ? node_t'(rd_data) : node_q;
	assign slot      = addr_q[btlpm_pkg::ADDR_W-1] ? node_cur.right : node_cur.left;
	assign free_idx  = free_q[IDX_W-1:0];
	assign level_end = (depth_q == len_q);
	assign pool_full = (free_q == FREE_W'(NODES));
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign hit_now   = hit_q || node_cur.vld;
	assign best_now  = node_cur.vld ? node_cur.id : best_q;

	always_comb begin
		finish   = 1'b0;
		descend  = 1'b0;
		alloc    = 1'b0;
		do_write = 1'b0;
		node_wr  = node_cur;
		rsp_next.hit      = 1'b0;
		rsp_next.match_id = '0;
		rsp_next.status   = btlpm_pkg::STATUS_DONE;
		if (state_q == ST_STEP) begin
			if (lookup_q) begin
				if (level_end || slot == '0) begin
					finish       = 1'b1;
					rsp_next.hit = hit_now;
					if (hit_now) begin
						rsp_next.match_id = btlpm_pkg::ROUTE_W'(best_now);
					end
				end else begin
					descend = 1'b1;
				end
			end else begin
				if (level_end) begin
					finish      = 1'b1;
					do_write    = 1'b1;
					node_wr.vld = 1'b1;
					node_wr.id  = id_q;
				end else if (slot != '0) begin
					descend = 1'b1;
				end else if (pool_full) begin
					// The current node may be a fresh one still unwritten.
					finish          = 1'b1;
					do_write        = 1'b1;
					rsp_next.status = btlpm_pkg::STATUS_FULL;
				end else begin
					alloc    = 1'b1;
					do_write = 1'b1;
					if (addr_q[btlpm_pkg::ADDR_W-1]) begin
						node_wr.right = free_idx;
					end else begin
						node_wr.left = free_idx;
					end
				end
			end
		end
	end

	// A finishing step waits until the response register can take the beat.
	assign advance   = !finish || out_free;
	assign cmd_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	btlpm_ram #(
		.WIDTH (ENT_W),
		.DEPTH (NODES)
	) u_node_ram (
		.clk     (clk),
		.wr_en   (do_write && advance && cur_q != '0),
		.wr_addr (cur_q),
		.wr_data (ENT_W'(node_wr)),
		.rd_en   (descend),
		.rd_addr (slot),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk) begin
		if (finish && out_free) begin
			rsp_q <= rsp_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lookup_q    <= 1'b0;
			addr_q      <= '0;
			len_q       <= '0;
			depth_q     <= '0;
			id_q        <= '0;
			cur_q       <= '0;
			node_q      <= '0;
			from_ram_q  <= 1'b0;
			hit_q       <= 1'b0;
			best_q      <= '0;
			free_q      <= FREE_W'(1);
			root_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready && !(finish && advance)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_hs_in.valid && cmd_hs_in.ready) begin
						state_q    <= ST_STEP;
						lookup_q   <= cmd.lookup;
						addr_q     <= cmd.addr;
						len_q      <= cmd.depth;
						depth_q    <= '0;
						id_q       <= ID_BITS'(cmd.route_id);
						cur_q      <= '0;
						node_q     <= root_q;
						from_ram_q <= 1'b0;
						hit_q      <= 1'b0;
						best_q     <= '0;
					end
				end
				ST_STEP: begin
					if (advance) begin
						if (do_write && cur_q == '0) begin
							root_q <= node_wr;
						end
						if (finish) begin
							state_q     <= ST_IDLE;
							rsp_valid_q <= 1'b1;
						end
						if (descend) begin
							cur_q      <= slot;
							from_ram_q <= 1'b1;
							hit_q      <= hit_now;
							best_q     <= best_now;
						end
						if (alloc) begin
							cur_q      <= free_idx;
							node_q     <= '0;
							from_ram_q <= 1'b0;
							free_q     <= free_q + FREE_W'(1);
						end
						if (descend || alloc) begin
							depth_q <= depth_q + btlpm_pkg::LEN_W'(1);
							addr_q  <= {addr_q[btlpm_pkg::ADDR_W-2:0], 1'b0};
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/binary_trie_longest_prefix_match.sv
// Longest prefix match engine over a binary trie: insert prefixes, look up
// addresses, one trie level per clock cycle in the walker. An operation on a
// prefix of length L (a lookup walks up to 32 levels, stopping early where the
// path ends) runs down to level L, and the walker takes the next one only
// once its response is registered; each level waits on the node RAM read of
// the level before, whose result decides the next address. A two-entry
// command queue and a response register let request and response beats flow
// while the walker is busy. The root node lives in flip-flops and is cleared
// by reset; all other nodes sit in RAM and start from a clear value when
// allocated, so no clearing pass is needed. An insert that runs out of nodes
// responds with status full and keeps the nodes it already made.
// Depends on btlpm_pkg, btlpm_front, btlpm_walk and btlpm_ram.
`timescale 1ns / 1ps
`default_nettype none

module binary_trie_longest_prefix_match #(
	parameter int NODES   = btlpm_pkg::NODES_DEF,
	parameter int ID_BITS = btlpm_pkg::ID_BITS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire btlpm_pkg::req_t req,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output btlpm_pkg::rsp_t      rsp
);

	btlpm_pkg::hs_t  cmd_hs;
	btlpm_pkg::cmd_t cmd;
	logic            cmd_ready;

	btlpm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.cmd_hs_out (cmd_hs),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd)
	);

	btlpm_walk #(
		.NODES   (NODES),
		.ID_BITS (ID_BITS)
	) u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_hs_in (cmd_hs),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
